// ===== rtl/shk_pkg.sv =====
// Shared constants, payload types and control types of the string key hash set.
`timescale 1ns / 1ps
package shk_pkg;

    localparam int BUCKETS       = 8;
    localparam int CAPACITY      = 64;
    localparam int MAX_KEY_BYTES = 29;

    localparam int KEY_BYTES  = 29;
    localparam int KEY_BITS   = KEY_BYTES * 8;
    localparam int WORD_W     = 64;
    localparam int WORD3_W    = 40;
    localparam int WORDS      = 4;
    localparam int WORD_IDX_W = 2;
    localparam int LEN_W      = 5;
    localparam int BKT_W      = 3;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W      = $clog2(MAX_KEY_BYTES * 255 + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_MEMBER = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd                cmd;
        logic [LEN_W-1:0]    key_len;
        logic [WORD_W-1:0]   key_word0;
        logic [WORD_W-1:0]   key_word1;
        logic [WORD_W-1:0]   key_word2;
        logic [WORD3_W-1:0]  key_word3;
    } t_in;

    typedef struct packed {
        logic             found;
        logic             status;
        logic [BKT_W-1:0] bucket_index;
    } t_out;

    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [BKT_W-1:0]    bkt;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    typedef struct packed {
        logic                  load;
        logic                  hash_en;
        logic [WORD_IDX_W-1:0] hash_word;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  commit;
        logic                  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_clear;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/shk_ctrl.sv =====
// Sequencer of the hash set: key hashing, store scan, commit and result hand-off.
`timescale 1ns / 1ps
module shk_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  shk_pkg::t_dp_sts i_sts,
    output shk_pkg::t_dp_cmd o_cmd
);
    import shk_pkg::*;

    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(CAPACITY - 1);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(WORDS - 1);

    t_state                r_state, n_state;
    logic [WORD_IDX_W-1:0] r_word, n_word;
    logic [ADDR_W-1:0]     r_addr, n_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_word  <= '0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_addr  <= n_addr;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_word          = r_word;
        n_addr          = r_addr;
        o_cmd           = '0;
        o_cmd.hash_word = r_word;
        o_cmd.rd_addr   = r_addr;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_word     = '0;
                    n_state    = ST_HASH;
                end
            end
            ST_HASH: begin
                o_cmd.hash_en = 1'b1;
                n_word        = r_word + 1'b1;
                if (r_word == LAST_WORD) begin
                    n_addr  = '0;
                    n_state = i_sts.is_clear ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            // last compare lands here
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== rtl/shk_dp.sv =====
// Datapath of the hash set: key masking, byte-sum hash, entry store and result register.
`timescale 1ns / 1ps
module shk_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  shk_pkg::t_in     i_in_data,
    input  shk_pkg::t_dp_cmd i_cmd,
    output shk_pkg::t_dp_sts o_sts,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output shk_pkg::t_out    o_out_data
);
    import shk_pkg::*;

    localparam int PAD_BITS = WORDS * WORD_W - KEY_BITS;

    t_entry                r_mem [CAPACITY];
    logic [CAPACITY-1:0]   r_valid, n_valid;

    t_cmd                  r_op;
    logic [LEN_W-1:0]      r_len;
    logic [KEY_BITS-1:0]   r_key;
    logic [SUM_W-1:0]      r_sum;

    t_entry                r_rd_data;
    logic                  r_cmp_vld;
    logic                  r_cmp_slot_vld;
    logic [ADDR_W-1:0]     r_cmp_addr;

    logic                  r_hit;
    logic [ADDR_W-1:0]     r_hit_idx;
    logic                  r_free_ok;
    logic [ADDR_W-1:0]     r_free_idx;

    logic                  r_out_valid;
    t_out                  r_out, n_out;

    logic [LEN_W-1:0]      len_c;
    logic [KEY_BITS-1:0]   key_raw;
    logic [KEY_BITS-1:0]   key_masked;
    logic [WORDS*WORD_W-1:0] key_pad;
    logic [WORD_W-1:0]     hash_word;
    logic [SUM_W-1:0]      word_sum;
    logic [BKT_W-1:0]      bucket;
    logic                  match;
    logic                  ins_ok;
    logic                  out_free;

    // clamp the length and zero every byte past it
    always_comb begin
        len_c = (i_in_data.key_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES)
                                                            : i_in_data.key_len;
        key_raw = {i_in_data.key_word3, i_in_data.key_word2,
                   i_in_data.key_word1, i_in_data.key_word0};
        for (int b = 0; b < KEY_BYTES; b++) begin
            key_masked[b*8 +: 8] = (LEN_W'(b) < len_c) ? key_raw[b*8 +: 8] : 8'h00;
        end
    end

    // one key word of eight bytes per hash step
    always_comb begin
        key_pad   = {{PAD_BITS{1'b0}}, r_key};
        hash_word = key_pad[i_cmd.hash_word*WORD_W +: WORD_W];
        word_sum  = '0;
        for (int b = 0; b < 8; b++) begin
            word_sum = word_sum + SUM_W'(hash_word[b*8 +: 8]);
        end
    end

    // BUCKETS is a power of two: the remainder is a mask
    assign bucket = BKT_W'(r_sum % BUCKETS);

    assign match = r_cmp_vld && r_cmp_slot_vld
                && (r_rd_data.len == r_len)
                && (r_rd_data.bkt == bucket)
                && (r_rd_data.key == r_key);

    assign ins_ok = i_cmd.commit && (r_op == CMD_INSERT) && r_free_ok;

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.commit) begin
            case (r_op)
                CMD_CLEAR:  n_valid = '0;
                CMD_DELETE: if (r_hit) n_valid[r_hit_idx] = 1'b0;
                CMD_INSERT: if (r_free_ok) n_valid[r_free_idx] = 1'b1;
                default:    n_valid = r_valid;
            endcase
        end
    end

    always_comb begin
        n_out.found        = r_hit;
        n_out.status       = (r_op == CMD_INSERT) && !r_free_ok;
        n_out.bucket_index = (r_op == CMD_CLEAR) ? '0 : bucket;
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_cmp_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end else if (r_cmp_vld) begin
                if (match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!r_cmp_slot_vld && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_data.cmd;
            r_len <= len_c;
            r_key <= key_masked;
            r_sum <= '0;
        end else if (i_cmd.hash_en) begin
            r_sum <= r_sum + word_sum;
        end
        r_cmp_addr     <= i_cmd.rd_addr;
        r_cmp_slot_vld <= r_valid[i_cmd.rd_addr];
        // keep the lowest hit and the lowest free slot
        if (r_cmp_vld && match && !r_hit) begin
            r_hit_idx <= r_cmp_addr;
        end
        if (r_cmp_vld && !r_cmp_slot_vld && !r_free_ok) begin
            r_free_idx <= r_cmp_addr;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins_ok) begin
            r_mem[r_free_idx] <= '{len: r_len, bkt: bucket, key: r_key};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    assign o_sts.is_clear = (r_op == CMD_CLEAR);
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    a_ins_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_ok |-> !r_valid[r_free_idx])
        else $error("insert targets an occupied slot");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_ok |=> ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("insert did not add exactly one entry");

    a_del_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_op == CMD_DELETE) && r_hit) |-> r_valid[r_hit_idx])
        else $error("delete hit points at an empty slot");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_op == CMD_CLEAR)) |=> (r_valid == '0))
        else $error("clear left entries in the store");

endmodule

// ===== rtl/string_key_hash_set.sv =====
// Top level of the string key hash set: sequencer plus datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel i_in_valid / o_in_stall carries one command with a key of up
//   to 29 bytes (insert, delete, member, clear). Output channel o_out_valid /
//   i_out_stall returns exactly one result per command: found, status, bucket.
//   A transfer happens on a rising edge with valid high and stall low.
// Timing:
//   A command is hashed one key word per cycle over its four key words, then the
//   entry store is scanned one slot per cycle through its single read port,
//   with a registered read, then the command is committed. A clear skips the
//   scan. One command is in flight at a time, so the block takes no new command
//   until the result of the last one has been loaded into the output register.
// Reset:
//   i_rst_n low empties the store and the result register; no sweep is needed.
// Back-pressure:
//   A finished result sits in the output register while i_out_stall is high;
//   the next command is still accepted and worked on, and waits for the
//   register to drain before its own result is loaded.
module string_key_hash_set_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  shk_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output shk_pkg::t_out o_out_data
);
    import shk_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    shk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    shk_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
